// ===== hdl/bfm_pkg.sv =====
// bfm_pkg: shared types and constants of the tape-language stepping machine
// no dependencies
`default_nettype none

package bfm_pkg;

  localparam int unsigned PROG_DEPTH = 1024;
  localparam int unsigned PROG_AW    = 10;
  localparam int unsigned PC_W       = 11;
  localparam int unsigned DATA_DEPTH = 32;
  localparam int unsigned DATA_AW    = 5;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_INC   = 8'h2B;
  localparam logic [7:0] OP_DEC   = 8'h2D;
  localparam logic [7:0] OP_OUT   = 8'h2E;
  localparam logic [7:0] OP_IN    = 8'h2C;
  localparam logic [7:0] OP_OPEN  = 8'h5B;
  localparam logic [7:0] OP_CLOSE = 8'h5D;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_EXEC    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_FAULT = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [9:0]  addr;
    logic [7:0]  prog_byte;
    logic [7:0]  in_value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               out_valid;
    logic signed [7:0]  out_value;
    logic [10:0]        pc_now;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/bfm_ram.sv =====
// bfm_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module bfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bfm_cfg.sv =====
// bfm_cfg: register port holding the program length; its run-length output is clamped to the store size
// depends on bfm_pkg
`default_nettype none

module bfm_cfg
  import bfm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [PC_W-1:0]    run_len_o
);

  localparam logic REG_PROG_LEN = 1'b0;

  logic [PC_W-1:0] len_q, len_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PROG_LEN);

  always_comb begin
    len_d = len_q;
    if (wr_en) begin
      len_d = pwdata[PC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign prdata    = (paddr[2] == REG_PROG_LEN) ? 32'(len_q) : '0;
  assign run_len_o = (len_q > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : len_q;

endmodule

`default_nettype wire

// ===== hdl/brainfuck_machine_step.sv =====
// brainfuck_machine_step: one instruction per word over a program memory and a cell memory
// a word runs in S_EXEC (a taken bracket then scans byte by byte in S_SCANF or S_SCANB) and its
// result is registered or parked in S_HOLD; words are accepted only in S_IDLE, one at a time
// reset clears pc, pointer, fault, length and the cell valid flags; program store undefined
// depends on bfm_pkg, bfm_ram, bfm_cfg
`default_nettype none

module brainfuck_machine_step
  import bfm_pkg::*;
#(
  parameter int unsigned CELL_WIDTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  req_t               req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output rsp_t               rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCANF = 5'b00100,
    S_SCANB = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic [9:0]            addr_q;
  logic [7:0]            inval_q;
  logic [DATA_AW-1:0]    cell_a_q;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic [DATA_AW-1:0]    ptr_q, ptr_d;
  logic                  fault_q, fault_d;
  logic [DATA_DEPTH-1:0] vld_q, vld_d;
  logic [PC_W-1:0]       scan_q, scan_d;
  logic [PC_W-1:0]       depth_q, depth_d;
  rsp_t                  rsp_q, rsp_d, hold_q, hold_d, res;
  logic                  rsp_vld_q, rsp_vld_d;

  logic                  accept, rsp_free, finish;
  logic [PC_W-1:0]       run_len, p_nxt, depth_n;
  logic [PROG_AW-1:0]    prog_ra;
  logic [7:0]            op;
  logic [DATA_AW-1:0]    cell_ra;
  logic [CELL_WIDTH-1:0] cell_rd, cur_val, dwd;
  logic                  dwe, res_ov;
  logic [7:0]            res_val;

  bfm_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .run_len_o (run_len)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_free    = !rsp_vld_q || rsp_ready_i;
  assign cell_ra     = (req_i.cmd == CMD_READ) ? req_i.addr[DATA_AW-1:0] : ptr_q;

  bfm_ram #(
    .WIDTH (8),
    .DEPTH (PROG_DEPTH)
  ) u_prog_ram (
    .clk_i,
    .we_i    (accept && (req_i.cmd == CMD_WRITE)),
    .waddr_i (req_i.addr[PROG_AW-1:0]),
    .wdata_i (req_i.prog_byte),
    .raddr_i (prog_ra),
    .rdata_o (op)
  );

  bfm_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (DATA_DEPTH)
  ) u_cell_ram (
    .clk_i,
    .we_i    (dwe),
    .waddr_i (ptr_q),
    .wdata_i (dwd),
    .raddr_i (cell_ra),
    .rdata_o (cell_rd)
  );

  assign cur_val = vld_q[cell_a_q] ? cell_rd : '0;

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    ptr_d     = ptr_q;
    fault_d   = fault_q;
    vld_d     = vld_q;
    scan_d    = scan_q;
    depth_d   = depth_q;
    hold_d    = hold_q;
    rsp_d     = rsp_q;
    rsp_vld_d = rsp_vld_q && !rsp_ready_i;
    prog_ra   = pc_q[PROG_AW-1:0];
    finish    = 1'b0;
    res_ov    = 1'b0;
    res_val   = '0;
    dwe       = 1'b0;
    dwd       = cur_val;
    p_nxt     = '0;
    depth_n   = depth_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        finish = 1'b1;
        unique case (cmd_q)
          CMD_WRITE: begin
          end
          CMD_RESTART: begin
            vld_d   = '0;
            pc_d    = '0;
            ptr_d   = '0;
            fault_d = 1'b0;
          end
          CMD_READ: begin
            if (addr_q < 10'(DATA_DEPTH)) begin
              res_ov  = 1'b1;
              res_val = cur_val[7:0];
            end
          end
          CMD_EXEC: begin
            if (!fault_q && (pc_q < run_len)) begin
              pc_d = pc_q + PC_W'(1);
              case (op)
                OP_RIGHT: begin
                  if (ptr_q == DATA_AW'(DATA_DEPTH - 1)) begin
                    fault_d = 1'b1;
                    pc_d    = pc_q;
                  end else begin
                    ptr_d = ptr_q + DATA_AW'(1);
                  end
                end
                OP_LEFT: begin
                  if (ptr_q == '0) begin
                    fault_d = 1'b1;
                    pc_d    = pc_q;
                  end else begin
                    ptr_d = ptr_q - DATA_AW'(1);
                  end
                end
                OP_INC: begin
                  dwe          = 1'b1;
                  dwd          = cur_val + CELL_WIDTH'(1);
                  vld_d[ptr_q] = 1'b1;
                end
                OP_DEC: begin
                  dwe          = 1'b1;
                  dwd          = cur_val - CELL_WIDTH'(1);
                  vld_d[ptr_q] = 1'b1;
                end
                OP_IN: begin
                  dwe          = 1'b1;
                  dwd          = CELL_WIDTH'(inval_q);
                  vld_d[ptr_q] = 1'b1;
                end
                OP_OUT: begin
                  res_ov  = 1'b1;
                  res_val = cur_val[7:0];
                end
                OP_OPEN: begin
                  if (cur_val == '0) begin
                    p_nxt = pc_q + PC_W'(1);
                    pc_d  = pc_q;
                    if (p_nxt >= run_len) begin
                      fault_d = 1'b1;
                    end else begin
                      finish  = 1'b0;
                      scan_d  = p_nxt;
                      depth_d = PC_W'(1);
                      prog_ra = p_nxt[PROG_AW-1:0];
                      state_d = S_SCANF;
                    end
                  end
                end
                OP_CLOSE: begin
                  if (cur_val != '0) begin
                    pc_d = pc_q;
                    if (pc_q == '0) begin
                      fault_d = 1'b1;
                    end else begin
                      p_nxt   = pc_q - PC_W'(1);
                      finish  = 1'b0;
                      scan_d  = p_nxt;
                      depth_d = PC_W'(1);
                      prog_ra = p_nxt[PROG_AW-1:0];
                      state_d = S_SCANB;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
          end
        endcase
      end
      S_SCANF: begin
        if (op == OP_OPEN) begin
          depth_n = depth_q + PC_W'(1);
        end else if (op == OP_CLOSE) begin
          depth_n = depth_q - PC_W'(1);
        end
        p_nxt = scan_q + PC_W'(1);
        if (depth_n == '0) begin
          pc_d   = p_nxt;
          finish = 1'b1;
        end else if (p_nxt >= run_len) begin
          fault_d = 1'b1;
          finish  = 1'b1;
        end else begin
          scan_d  = p_nxt;
          depth_d = depth_n;
          prog_ra = p_nxt[PROG_AW-1:0];
        end
      end
      S_SCANB: begin
        if (op == OP_CLOSE) begin
          depth_n = depth_q + PC_W'(1);
        end else if (op == OP_OPEN) begin
          depth_n = depth_q - PC_W'(1);
        end
        p_nxt = scan_q - PC_W'(1);
        if (depth_n == '0) begin
          pc_d   = scan_q + PC_W'(1);
          finish = 1'b1;
        end else if (scan_q == '0) begin
          fault_d = 1'b1;
          finish  = 1'b1;
        end else begin
          scan_d  = p_nxt;
          depth_d = depth_n;
          prog_ra = p_nxt[PROG_AW-1:0];
        end
      end
      S_HOLD: begin
        if (rsp_free) begin
          rsp_d     = hold_q;
          rsp_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.out_valid = res_ov;
    res.out_value = res_val;
    res.pc_now    = pc_d;
    if (fault_d) begin
      res.status = ST_FAULT;
    end else if (pc_d >= run_len) begin
      res.status = ST_HALT;
    end else begin
      res.status = ST_RUN;
    end

    if (finish) begin
      if (rsp_free) begin
        rsp_d     = res;
        rsp_vld_d = 1'b1;
        state_d   = S_IDLE;
      end else begin
        hold_d  = res;
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      ptr_q     <= '0;
      fault_q   <= 1'b0;
      vld_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      ptr_q     <= ptr_d;
      fault_q   <= fault_d;
      vld_q     <= vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= req_i.cmd;
      addr_q   <= req_i.addr;
      inval_q  <= req_i.in_value;
      cell_a_q <= cell_ra;
    end
    scan_q  <= scan_d;
    depth_q <= depth_d;
    hold_q  <= hold_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted word did not enter execution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q && !(state_q == S_EXEC && cmd_q == CMD_RESTART)) |=> fault_q)
    else $error("fault cleared without restart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCANF || state_q == S_SCANB) |-> (depth_q != '0))
    else $error("bracket scan running with zero nesting depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dwe |-> (state_q == S_EXEC && cmd_q == CMD_EXEC))
    else $error("cell write outside instruction execution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> rsp_vld_q)
    else $error("result parked while output register empty");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_brainfuck_machine_step.sv =====
// tb_brainfuck_machine_step: self-checking bench for the tape-language stepping machine
// drives words and apb writes and reads, predicts every response word and compares it field by field
// depends on bfm_pkg and brainfuck_machine_step
`default_nettype none

module tb_brainfuck_machine_step;
  import bfm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_PROG_LENGTH = 0;
  localparam logic [PADDR_W-1:0] REG_PROG_LENGTH_ADDR = PADDR_W'(4 * REG_PROG_LENGTH);
  localparam logic [7:0] BYTE_IGNORED = 8'h78;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               req_valid_i;
  logic               req_ready_o;
  req_t               req_i;
  logic               rsp_valid_o;
  logic               rsp_ready_i;
  rsp_t               rsp_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  brainfuck_machine_step i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // machine copy kept by the bench
  logic [7:0]  prog_mem [PROG_DEPTH];
  bit          prog_written [PROG_DEPTH];
  logic [7:0]  tape [DATA_DEPTH];
  int unsigned pc_m;
  int unsigned ptr_m;
  bit          fault_m;
  logic [10:0] len_reg;

  rsp_t        rsp_due_q [$];
  int unsigned err_cnt;
  int unsigned words_sent;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic int unsigned run_len();
    return (len_reg > PROG_DEPTH) ? PROG_DEPTH : int'(len_reg);
  endfunction

  function automatic void clear_machine();
    foreach (tape[i]) tape[i] = 8'd0;
    pc_m = 0;
    ptr_m = 0;
    fault_m = 1'b0;
  endfunction

  // bracket partner search from pc; blind_at marks a byte never loaded
  function automatic void find_partner(input bit fwd, output int unsigned dest,
                                       output bit found, output int blind_at);
    int unsigned depth;
    int unsigned p;
    depth = 1;
    p = pc_m;
    found = 1'b0;
    blind_at = -1;
    dest = 0;
    while (depth != 0) begin
      if (fwd) begin
        p++;
        if (p >= run_len()) return;
      end else begin
        if (p == 0) return;
        p--;
      end
      if (!prog_written[p]) begin
        blind_at = p;
        return;
      end
      if (prog_mem[p] == (fwd ? OP_OPEN : OP_CLOSE)) depth++;
      else if (prog_mem[p] == (fwd ? OP_CLOSE : OP_OPEN)) depth--;
    end
    found = 1'b1;
    dest = p + 1;
  endfunction

  function automatic rsp_t step_machine(input req_t w);
    rsp_t        r;
    logic [7:0]  cur;
    logic [7:0]  emit;
    bit          emitted;
    bit          step_on;
    bit          found;
    int unsigned dest;
    int          blind;
    r = '0;
    emit = 8'd0;
    emitted = 1'b0;
    case (w.cmd)
      CMD_WRITE: begin
        prog_mem[w.addr] = w.prog_byte;
        prog_written[w.addr] = 1'b1;
      end
      CMD_EXEC: begin
        if (!fault_m && pc_m < run_len()) begin
          cur = tape[ptr_m];
          step_on = 1'b1;
          case (prog_mem[pc_m])
            OP_RIGHT: begin
              if (ptr_m == DATA_DEPTH - 1) begin
                fault_m = 1'b1;
                step_on = 1'b0;
              end else ptr_m = ptr_m + 1;
            end
            OP_LEFT: begin
              if (ptr_m == 0) begin
                fault_m = 1'b1;
                step_on = 1'b0;
              end else ptr_m = ptr_m - 1;
            end
            OP_INC: tape[ptr_m] = cur + 8'd1;
            OP_DEC: tape[ptr_m] = cur - 8'd1;
            OP_OUT: begin
              emitted = 1'b1;
              emit = cur;
            end
            OP_IN: tape[ptr_m] = w.in_value;
            OP_OPEN: begin
              if (cur == 8'd0) begin
                find_partner(1'b1, dest, found, blind);
                if (found) pc_m = dest;
                else fault_m = 1'b1;
                step_on = 1'b0;
              end
            end
            OP_CLOSE: begin
              if (cur != 8'd0) begin
                find_partner(1'b0, dest, found, blind);
                if (found) pc_m = dest;
                else fault_m = 1'b1;
                step_on = 1'b0;
              end
            end
            default: ;
          endcase
          if (step_on) pc_m = pc_m + 1;
        end
      end
      CMD_READ: begin
        if (w.addr < DATA_DEPTH) begin
          emitted = 1'b1;
          emit = tape[w.addr[DATA_AW-1:0]];
        end
      end
      default: clear_machine();
    endcase
    r.status = fault_m ? ST_FAULT : ((pc_m >= run_len()) ? ST_HALT : ST_RUN);
    r.out_valid = emitted;
    r.out_value = emitted ? emit : 8'd0;
    r.pc_now = 11'(pc_m);
    return r;
  endfunction

  // address that must be loaded before the next instruction may run, or -1
  function automatic int fill_needed();
    int unsigned dest;
    bit          found;
    int          blind;
    if (fault_m || pc_m >= run_len()) return -1;
    if (!prog_written[pc_m]) return pc_m;
    if (prog_mem[pc_m] == OP_OPEN && tape[ptr_m] == 8'd0) begin
      find_partner(1'b1, dest, found, blind);
      return blind;
    end
    if (prog_mem[pc_m] == OP_CLOSE && tape[ptr_m] != 8'd0) begin
      find_partner(1'b0, dest, found, blind);
      return blind;
    end
    return -1;
  endfunction

  function automatic req_t make_word(input cmd_e cmd, input logic [9:0] addr,
                                     input logic [7:0] pb, input logic [7:0] iv);
    req_t w;
    w.cmd = cmd;
    w.addr = addr;
    w.prog_byte = pb;
    w.in_value = iv;
    return w;
  endfunction

  function automatic logic [7:0] rand_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 24) return OP_INC;
    if (r < 34) return OP_DEC;
    if (r < 48) return OP_RIGHT;
    if (r < 55) return OP_LEFT;
    if (r < 67) return OP_OUT;
    if (r < 75) return OP_IN;
    if (r < 84) return OP_OPEN;
    if (r < 93) return OP_CLOSE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input req_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (!req_ready_o);
    rsp_due_q.push_back(step_machine(w));
    words_sent++;
  endtask

  task automatic send_exec();
    int gap;
    gap = fill_needed();
    if (gap >= 0) begin
      send_word(make_word(CMD_WRITE, 10'(gap), rand_op(), 8'($urandom_range(0, 255))));
    end else begin
      send_word(make_word(CMD_EXEC, 10'($urandom_range(0, 1023)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    end
  endtask

  task automatic send_restart();
    send_word(make_word(CMD_RESTART, 10'($urandom_range(0, 1023)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
  endtask

  task automatic send_read(input logic [9:0] addr);
    send_word(make_word(CMD_READ, addr, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255))));
  endtask

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rsp_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_prog_length(input logic [10:0] len);
    logic [31:0] rd;
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_PROG_LENGTH_ADDR;
    pwdata <= 32'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    len_reg = len;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[10:0] !== len)
      flag_error($sformatf("length register read expected %0d got %0d", len, rd[10:0]));
    @(posedge clk_i);
  endtask

  // mostly balanced brackets, with an occasional unconstrained byte
  task automatic load_program(input int unsigned len);
    int unsigned depth_open;
    logic [7:0]  b;
    depth_open = 0;
    for (int unsigned a = 0; a < len; a++) begin
      if ($urandom_range(0, 9) == 0) b = rand_op();
      else if (len - a <= depth_open) b = OP_CLOSE;
      else begin
        b = rand_op();
        if (b == OP_OPEN && len - a <= depth_open + 1) b = OP_INC;
        if (b == OP_CLOSE && depth_open == 0) b = OP_INC;
      end
      if (b == OP_OPEN) depth_open++;
      else if (b == OP_CLOSE && depth_open > 0) depth_open--;
      send_word(make_word(CMD_WRITE, 10'(a), b, 8'($urandom_range(0, 255))));
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    set_prog_length(11'd0);
    send_word(make_word(CMD_EXEC, 10'd0, 8'd0, 8'd0));
    send_read(10'd0);
    send_read(10'd31);
    send_read(10'd32);
    send_read(10'd1023);
    send_word(make_word(CMD_WRITE, 10'd1023, 8'hFF, 8'hFF));
    send_word(make_word(CMD_WRITE, 10'd0, OP_IN, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd1, OP_OUT, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd2, OP_DEC, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd3, OP_OUT, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd4, OP_IN, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd5, OP_OPEN, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd6, OP_CLOSE, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd7, BYTE_IGNORED, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd8, OP_LEFT, 8'd0));
    set_prog_length(11'd9);
    send_word(make_word(CMD_EXEC, 10'd0, 8'd0, 8'h80));
    repeat (3) send_word(make_word(CMD_EXEC, 10'd0, 8'd0, 8'd0));
    send_word(make_word(CMD_EXEC, 10'd0, 8'd0, 8'h00));
    repeat (4) send_word(make_word(CMD_EXEC, 10'd0, 8'd0, 8'd0));
    send_read(10'd0);
    send_restart();
  endtask

  task automatic test_bracket_faults();
    set_prog_length(11'd2);
    send_word(make_word(CMD_WRITE, 10'd0, OP_INC, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd1, OP_CLOSE, 8'd0));
    send_restart();
    repeat (3) send_exec();
    send_word(make_word(CMD_WRITE, 10'd0, OP_OPEN, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd1, OP_INC, 8'd0));
    send_restart();
    repeat (2) send_exec();
    set_prog_length(11'd5);
    send_word(make_word(CMD_WRITE, 10'd0, OP_INC, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd1, OP_INC, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd2, OP_OPEN, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd3, OP_DEC, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd4, OP_CLOSE, 8'd0));
    send_restart();
    repeat (9) send_exec();
  endtask

  task automatic test_right_edge();
    set_prog_length(11'd5);
    send_word(make_word(CMD_WRITE, 10'd0, OP_INC, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd1, OP_OPEN, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd2, OP_RIGHT, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd3, OP_INC, 8'd0));
    send_word(make_word(CMD_WRITE, 10'd4, OP_CLOSE, 8'd0));
    send_restart();
    while (!fault_m) send_exec();
    send_exec();
    send_read(10'd31);
    send_read(10'd30);
  endtask

  task automatic test_full_length();
    send_idle_pct = 20;
    stall_pct = 20;
    set_prog_length(11'(PROG_DEPTH));
    send_restart();
    repeat (150) begin
      if ($urandom_range(0, 9) == 0) send_read(10'($urandom_range(0, 31)));
      else if (fault_m && $urandom_range(0, 3) == 0) send_restart();
      else send_exec();
    end
  endtask

  task automatic test_random_runs(input int unsigned words, input int unsigned idle,
                                  input int unsigned stall);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    int unsigned steps;
    send_idle_pct = idle;
    stall_pct = stall;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = 0;
      else if (pick < 3) len = $urandom_range(33, 120);
      else len = $urandom_range(1, 32);
      set_prog_length(11'(len));
      load_program(len);
      send_restart();
      steps = $urandom_range(len + 4, 3 * len + 16);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if ((fault_m || pc_m >= run_len()) && pick < 40) send_restart();
        else if (pick < 84) send_exec();
        else if (pick < 92) begin
          if ($urandom_range(0, 3) == 0) send_read(10'($urandom_range(0, 1023)));
          else send_read(10'($urandom_range(0, 31)));
        end else if (pick < 97) begin
          send_word(make_word(CMD_WRITE, 10'($urandom_range(0, 1023)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        end else send_restart();
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_prog_length(11'd24);
    load_program(24);
    send_restart();
    hold_req++;
    repeat (60) begin
      if ($urandom_range(0, 7) == 0) send_read(10'($urandom_range(0, 31)));
      else if (fault_m) send_restart();
      else send_exec();
    end
  endtask

  always @(posedge clk_i) begin : rsp_side
    rsp_t due;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (rsp_due_q.size() == 0) begin
        flag_error($sformatf("unexpected word st %0d v %0b val %0d pc %0d",
                             rsp_o.status, rsp_o.out_valid, rsp_o.out_value, rsp_o.pc_now));
      end else begin
        due = rsp_due_q.pop_front();
        if (rsp_o.status !== due.status || rsp_o.out_valid !== due.out_valid ||
            rsp_o.out_value !== due.out_value || rsp_o.pc_now !== due.pc_now) begin
          flag_error($sformatf("expected st %0d v %0b val %0d pc %0d, got st %0d v %0b val %0d pc %0d",
                               due.status, due.out_valid, due.out_value, due.pc_now,
                               rsp_o.status, rsp_o.out_valid, rsp_o.out_value, rsp_o.pc_now));
        end
      end
    end
  end

  // receiver ready, with the long hold counted here
  always @(posedge clk_i) begin : ready_side
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ready_i <= 1'b0;
    end else rsp_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    rsp_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_cnt = 0;
    words_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    foreach (prog_mem[i]) begin
      prog_mem[i] = 8'd0;
      prog_written[i] = 1'b0;
    end
    clear_machine();
    len_reg = 11'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bracket_faults();
    test_right_edge();
    test_full_length();
    test_random_runs(200, 0, 0);
    test_random_runs(200, 61, 0);
    test_random_runs(200, 0, 61);
    test_random_runs(200, 26, 26);
    test_backpressure();
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== brainfuck_machine_step.f =====
hdl/bfm_pkg.sv
hdl/bfm_ram.sv
hdl/bfm_cfg.sv
hdl/brainfuck_machine_step.sv
verif/tb_brainfuck_machine_step.sv
